/* rtl/bpa_pkg.sv */
// bpa_pkg: shared types, constants and helper functions of the buddy page allocator
`default_nettype none
package bpa_pkg;

   localparam int PAGE_W    = 12;
   localparam int CNT_W     = 13;
   localparam int ORD_W     = 4;
   localparam int LINK_W    = 13;
   localparam int LIST_W    = 5;
   localparam int TOP_ORDER = 10;
   localparam int NLISTS    = 2 * (TOP_ORDER + 1);
   localparam int MAX_PAGES = 4096;
   localparam int META_W    = 6;
   localparam int CSR_IDX_W = 1;
   localparam int REQ_DW    = 32;
   localparam int REQ_UW    = 2;
   localparam int RSP_DW    = 24;

   localparam logic [LINK_W-1:0] EMPTY   = LINK_W'(MAX_PAGES);
   localparam logic [CNT_W-1:0]  CNT_MAX = {CNT_W{1'b1}};
   localparam logic [CNT_W-1:0]  MANAGED_MAX = CNT_W'(MAX_PAGES);

   localparam logic [CSR_IDX_W-1:0] REG_HIGH_ZONE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TOTAL     = 1'd1;

   typedef enum logic [1:0] {
      REQ_ADD       = 2'd0,
      REQ_ALLOC_LOW = 2'd1,
      REQ_ALLOC_ANY = 2'd2,
      REQ_FREE      = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOFREE  = 2'd1,
      ST_INVALID = 2'd2
   } rsp_code_type;

   // per-page block descriptor
   typedef struct packed {
      logic             head;
      logic             in_use;
      logic [ORD_W-1:0] ord;
   } meta_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_ADD_RD, S_ADD_TST, S_ADD_Z0, S_ADD_Z1, S_CARVE,
      S_PUSH_A, S_PUSH_B, S_AL_SRCH, S_AL_UNL, S_AL_SPLIT, S_AL_FIN,
      S_FR_TST, S_FR_CHK, S_FR_BUD, S_FR_PUSH, S_RESULT
   } state_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_CLEAR, OP_LOAD, OP_DECODE, OP_SCAN_RD, OP_SCAN_NEXT, OP_CARVE_Z0,
      OP_CARVE_Z1, OP_CARVE_STEP, OP_PUSH_A, OP_PUSH_B, OP_SRCH, OP_UNLINK_HEAD,
      OP_SPLIT, OP_ALLOC_FIN, OP_FREE_INIT, OP_BUD_RD, OP_BUD_MERGE, OP_FREE_PUSH,
      OP_RESULT
   } op_type;

   typedef struct packed {
      op_type       op;
      rsp_code_type code;
      logic         alloc;
   } cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic clr_last;
      logic add_empty;
      logic add_oob;
      logic head_hit;
      logic scan_end;
      logic need_z0;
      logic need_z1;
      logic carve_done;
      logic zone_hi;
      logic tail_valid;
      logic alloc_bad;
      logic list_hit;
      logic srch_last;
      logic split_more;
      logic free_bad_idx;
      logic free_bad_meta;
      logic top_ord;
      logic bud_out;
      logic bud_bad;
      logic rsp_busy;
   } dp_status_type;

   // largest order that fits in len, capped at the top order
   function automatic logic [ORD_W-1:0] fit_order(input logic [CNT_W-1:0] len);
      logic [ORD_W-1:0] r;
      r = '0;
      for (int i = 0; i < CNT_W; i++) begin
         if (len[i]) r = ORD_W'(i);
      end
      if (r > ORD_W'(TOP_ORDER)) r = ORD_W'(TOP_ORDER);
      return r;
   endfunction

   // smallest order whose block holds c pages (c at least one)
   function automatic logic [ORD_W-1:0] ceil_order(input logic [CNT_W-1:0] c);
      logic [CNT_W-1:0] v;
      logic [ORD_W-1:0] r;
      v = c - CNT_W'(1);
      r = '0;
      for (int i = 0; i < CNT_W; i++) begin
         if (v[i]) r = ORD_W'(i + 1);
      end
      return r;
   endfunction

   function automatic logic [LIST_W-1:0] list_idx(input logic z, input logic [ORD_W-1:0] o);
      return LIST_W'(o) + (z ? LIST_W'(TOP_ORDER + 1) : LIST_W'(0));
   endfunction

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
      return (a > b) ? a - b : '0;
   endfunction

endpackage
`default_nettype wire

/* rtl/bpa_ram.sv */
// bpa_ram: generic single-write, single-read ram with registered read data
`default_nettype none
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* rtl/bpa_ctrl.sv */
// bpa_ctrl: sequencer that steps the datapath through add, allocate and free
`default_nettype none
module bpa_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire bpa_pkg::dp_status_type stat,
   output bpa_pkg::cmd_type            cmd
);
   import bpa_pkg::*;

   state_type    state_ff, state_in;
   state_type    ret_ff, ret_in;
   rsp_code_type code_ff, code_in;
   logic         alloc_ff, alloc_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ret_ff   <= S_IDLE;
         code_ff  <= ST_OK;
         alloc_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         code_ff  <= code_in;
         alloc_ff <= alloc_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      code_in    = code_ff;
      alloc_in   = alloc_ff;
      req_tready = 1'b0;
      cmd        = '{op: OP_NOP, code: code_ff, alloc: alloc_ff};
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DECODE;
               code_in  = ST_OK;
               alloc_in = 1'b0;
            end
         end
         S_DECODE: begin
            cmd.op = OP_DECODE;
            unique case (stat.kind)
               REQ_ADD: begin
                  if (stat.add_empty) begin
                     state_in = S_RESULT;
                  end else if (stat.add_oob) begin
                     code_in  = ST_INVALID;
                     state_in = S_RESULT;
                  end else begin
                     state_in = S_ADD_RD;
                  end
               end
               REQ_ALLOC_LOW, REQ_ALLOC_ANY: begin
                  if (stat.alloc_bad) begin
                     code_in  = ST_INVALID;
                     state_in = S_RESULT;
                  end else begin
                     state_in = S_AL_SRCH;
                  end
               end
               REQ_FREE: begin
                  if (stat.free_bad_idx) begin
                     code_in  = ST_INVALID;
                     state_in = S_RESULT;
                  end else begin
                     state_in = S_FR_TST;
                  end
               end
               default: state_in = S_RESULT;
            endcase
         end
         S_ADD_RD: begin
            cmd.op   = OP_SCAN_RD;
            state_in = S_ADD_TST;
         end
         S_ADD_TST: begin
            cmd.op = OP_SCAN_NEXT;
            priority if (stat.head_hit) begin
               code_in  = ST_INVALID;
               state_in = S_RESULT;
            end else if (stat.scan_end) begin
               state_in = S_ADD_Z0;
            end else begin
               state_in = S_ADD_RD;
            end
         end
         S_ADD_Z0: begin
            cmd.op   = OP_CARVE_Z0;
            state_in = stat.need_z0 ? S_CARVE : S_ADD_Z1;
         end
         S_ADD_Z1: begin
            cmd.op   = OP_CARVE_Z1;
            state_in = stat.need_z1 ? S_CARVE : S_RESULT;
         end
         S_CARVE: begin
            cmd.op = OP_CARVE_STEP;
            if (stat.carve_done) begin
               state_in = stat.zone_hi ? S_RESULT : S_ADD_Z1;
            end else begin
               ret_in   = S_CARVE;
               state_in = S_PUSH_A;
            end
         end
         S_PUSH_A: begin
            cmd.op   = OP_PUSH_A;
            state_in = stat.tail_valid ? S_PUSH_B : ret_ff;
         end
         S_PUSH_B: begin
            cmd.op   = OP_PUSH_B;
            state_in = ret_ff;
         end
         S_AL_SRCH: begin
            cmd.op = OP_SRCH;
            priority if (stat.list_hit) begin
               state_in = S_AL_UNL;
            end else if (stat.srch_last) begin
               code_in  = ST_NOFREE;
               state_in = S_RESULT;
            end else begin
               state_in = S_AL_SRCH;
            end
         end
         S_AL_UNL: begin
            cmd.op   = OP_UNLINK_HEAD;
            state_in = S_AL_SPLIT;
         end
         S_AL_SPLIT: begin
            cmd.op = OP_SPLIT;
            if (stat.split_more) begin
               ret_in   = S_AL_SPLIT;
               state_in = S_PUSH_A;
            end else begin
               state_in = S_AL_FIN;
            end
         end
         S_AL_FIN: begin
            cmd.op   = OP_ALLOC_FIN;
            alloc_in = 1'b1;
            state_in = S_RESULT;
         end
         S_FR_TST: begin
            cmd.op = OP_FREE_INIT;
            if (stat.free_bad_meta) begin
               code_in  = ST_INVALID;
               state_in = S_RESULT;
            end else begin
               state_in = S_FR_CHK;
            end
         end
         S_FR_CHK: begin
            cmd.op   = OP_BUD_RD;
            state_in = (stat.top_ord || stat.bud_out) ? S_FR_PUSH : S_FR_BUD;
         end
         S_FR_BUD: begin
            cmd.op   = OP_BUD_MERGE;
            state_in = stat.bud_bad ? S_FR_PUSH : S_FR_CHK;
         end
         S_FR_PUSH: begin
            cmd.op   = OP_FREE_PUSH;
            ret_in   = S_RESULT;
            state_in = S_PUSH_A;
         end
         S_RESULT: begin
            cmd.op = OP_RESULT;
            if (!stat.rsp_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

/* rtl/bpa_dpath.sv */
// bpa_dpath: registers, free-list heads, page memories and result register
`default_nettype none
module bpa_dpath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [bpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bpa_pkg::CNT_W-1:0]         csr_wdata,
   input  wire logic [bpa_pkg::REQ_DW-1:0]        req_tdata,
   input  wire logic [bpa_pkg::REQ_UW-1:0]        req_tuser,
   input  wire bpa_pkg::cmd_type                  cmd,
   output bpa_pkg::dp_status_type                 stat,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [bpa_pkg::RSP_DW-1:0]        rsp_tdata
);
   import bpa_pkg::*;

   // configuration
   logic [CNT_W-1:0]  hz_ff, total_ff;
   // zone free counters and free-list ends
   logic [CNT_W-1:0]  zf_ff [2];
   logic [CNT_W-1:0]  zf_in [2];
   logic [LINK_W-1:0] first_ff [NLISTS];
   logic [LINK_W-1:0] first_in [NLISTS];
   logic [LINK_W-1:0] last_ff [NLISTS];
   logic [LINK_W-1:0] last_in [NLISTS];
   // request and working registers
   req_kind_type      kind_ff, kind_in;
   logic [PAGE_W-1:0] s_ff, s_in;
   logic [CNT_W-1:0]  c_ff, c_in;
   logic [CNT_W:0]    e_ff, e_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [CNT_W-1:0]  cur_ff, cur_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic              zone_ff, zone_in;
   logic [ORD_W-1:0]  ord_ff, ord_in;
   logic [ORD_W-1:0]  rord_ff, rord_in;
   logic [ORD_W-1:0]  srch_ff, srch_in;
   logic [CNT_W-1:0]  pp_ff, pp_in;
   logic [ORD_W-1:0]  po_ff, po_in;
   logic [LINK_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  bud_ff, bud_in;
   logic [PAGE_W-1:0] clr_ff, clr_in;
   // result register
   logic              rv_ff, rv_in;
   rsp_code_type      rcode_ff, rcode_in;
   logic [PAGE_W-1:0] rpage_ff, rpage_in;
   logic [ORD_W-1:0]  rord_out_ff, rord_out_in;

   // memory ports
   logic              meta_we, nxt_we, prv_we;
   logic [PAGE_W-1:0] meta_wa, nxt_wa, prv_wa, meta_ra, link_ra;
   meta_type          meta_wd, meta_rd;
   logic [LINK_W-1:0] nxt_wd, prv_wd, nxt_rd, prv_rd;
   logic [META_W-1:0] meta_rd_raw;

   bpa_ram #(.WIDTH(META_W), .DEPTH(MAX_PAGES)) u_meta (
      .clock(clock), .wr_en(meta_we), .wr_addr(meta_wa), .wr_data(META_W'(meta_wd)),
      .rd_addr(meta_ra), .rd_data(meta_rd_raw));
   bpa_ram #(.WIDTH(LINK_W), .DEPTH(MAX_PAGES)) u_next (
      .clock(clock), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_addr(link_ra), .rd_data(nxt_rd));
   bpa_ram #(.WIDTH(LINK_W), .DEPTH(MAX_PAGES)) u_prev (
      .clock(clock), .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
      .rd_addr(link_ra), .rd_data(prv_rd));

   assign meta_rd = meta_type'(meta_rd_raw);

   // derived values
   logic [CNT_W-1:0]  managed;
   logic [LIST_W-1:0] push_l, srch_l, ord_l;
   logic [LINK_W-1:0] push_t, srch_first;
   logic [ORD_W-1:0]  carve_o, cord;
   logic [CNT_W-1:0]  carve_sz, rel, ord_sz, bud;
   logic [CNT_W:0]    hz_w, s_w, z0_end, z1_beg;
   logic              rsp_busy;

   assign managed    = (total_ff > MANAGED_MAX) ? MANAGED_MAX : total_ff;
   assign push_l     = list_idx(zone_ff, po_ff);
   assign srch_l     = list_idx(zone_ff, srch_ff);
   assign ord_l      = list_idx(zone_ff, ord_ff);
   assign push_t     = last_ff[push_l];
   assign srch_first = first_ff[srch_l];
   assign carve_o    = fit_order(len_ff);
   assign carve_sz   = CNT_W'(1) << carve_o;
   assign cord       = ceil_order(c_ff);
   assign ord_sz     = CNT_W'(1) << ord_ff;
   assign rel        = cur_ff - (zone_ff ? hz_ff : CNT_W'(0));
   assign bud        = rel[ord_ff] ? cur_ff - ord_sz : cur_ff + ord_sz;
   assign hz_w       = {1'b0, hz_ff};
   assign s_w        = (CNT_W + 1)'(s_ff);
   assign z0_end     = (e_ff < hz_w) ? e_ff : hz_w;
   assign z1_beg     = (s_w > hz_w) ? s_w : hz_w;
   assign rsp_busy   = rv_ff && !rsp_tready;

   // status toward the controller
   always_comb begin
      stat.kind          = kind_ff;
      stat.clr_last      = &clr_ff;
      stat.add_empty     = (c_ff == '0);
      stat.add_oob       = (e_ff > {1'b0, managed});
      stat.head_hit      = meta_rd.head;
      stat.scan_end      = ((scan_ff + CNT_W'(1)) == e_ff[CNT_W-1:0]);
      stat.need_z0       = (s_w < hz_w);
      stat.need_z1       = (e_ff > hz_w);
      stat.carve_done    = (len_ff == '0);
      stat.zone_hi       = zone_ff;
      stat.tail_valid    = !push_t[LINK_W-1];
      stat.alloc_bad     = (c_ff == '0) || (c_ff > (CNT_W'(1) << TOP_ORDER));
      stat.list_hit      = !srch_first[LINK_W-1];
      stat.srch_last     = (srch_ff == ORD_W'(TOP_ORDER));
      stat.split_more    = (ord_ff > rord_ff);
      stat.free_bad_idx  = ((CNT_W)'(s_ff) >= managed);
      stat.free_bad_meta = !meta_rd.head || !meta_rd.in_use;
      stat.top_ord       = (ord_ff == ORD_W'(TOP_ORDER));
      stat.bud_out       = (bud >= managed) || ((bud >= hz_ff) != zone_ff);
      stat.bud_bad       = !(meta_rd.head && !meta_rd.in_use && (meta_rd.ord == ord_ff));
      stat.rsp_busy      = rsp_busy;
   end

   // datapath actions per command
   always_comb begin
      kind_in = kind_ff;  s_in = s_ff;  c_in = c_ff;  e_in = e_ff;
      scan_in = scan_ff;  cur_in = cur_ff;  len_in = len_ff;  zone_in = zone_ff;
      ord_in = ord_ff;  rord_in = rord_ff;  srch_in = srch_ff;
      pp_in = pp_ff;  po_in = po_ff;  tail_in = tail_ff;  bud_in = bud_ff;
      clr_in = clr_ff;
      zf_in = zf_ff;  first_in = first_ff;  last_in = last_ff;
      rcode_in = rcode_ff;  rpage_in = rpage_ff;  rord_out_in = rord_out_ff;
      rv_in = rv_ff && !rsp_tready;
      meta_we = 1'b0;  meta_wa = '0;  meta_wd = '0;  meta_ra = '0;
      nxt_we = 1'b0;  nxt_wa = '0;  nxt_wd = '0;
      prv_we = 1'b0;  prv_wa = '0;  prv_wd = '0;  link_ra = '0;
      unique case (cmd.op)
         OP_NOP: begin
         end
         OP_CLEAR: begin
            meta_we = 1'b1;
            meta_wa = clr_ff;
            clr_in  = clr_ff + PAGE_W'(1);
         end
         OP_LOAD: begin
            kind_in = req_kind_type'(req_tuser);
            s_in    = req_tdata[PAGE_W-1:0];
            c_in    = req_tdata[PAGE_W +: CNT_W];
            e_in    = (CNT_W + 1)'(req_tdata[PAGE_W-1:0])
                      + (CNT_W + 1)'(req_tdata[PAGE_W +: CNT_W]);
            scan_in = CNT_W'(req_tdata[PAGE_W-1:0]);
         end
         OP_DECODE: begin
            meta_ra = s_ff;
            cur_in  = CNT_W'(s_ff);
            rord_in = cord;
            srch_in = cord;
            zone_in = !((kind_ff == REQ_ALLOC_LOW) || (zf_ff[0] > c_ff));
         end
         OP_SCAN_RD: begin
            meta_ra = scan_ff[PAGE_W-1:0];
         end
         OP_SCAN_NEXT: begin
            scan_in = scan_ff + CNT_W'(1);
         end
         OP_CARVE_Z0: begin
            if (s_w < hz_w) begin
               cur_in  = CNT_W'(s_ff);
               len_in  = CNT_W'(z0_end - s_w);
               zone_in = 1'b0;
               zf_in[0] = sat_add(zf_ff[0], CNT_W'(z0_end - s_w));
            end
         end
         OP_CARVE_Z1: begin
            if (e_ff > hz_w) begin
               cur_in  = CNT_W'(z1_beg);
               len_in  = CNT_W'(e_ff - z1_beg);
               zone_in = 1'b1;
               zf_in[1] = sat_add(zf_ff[1], CNT_W'(e_ff - z1_beg));
            end
         end
         OP_CARVE_STEP: begin
            if (len_ff != '0) begin
               pp_in  = cur_ff;
               po_in  = carve_o;
               cur_in = cur_ff + carve_sz;
               len_in = len_ff - carve_sz;
            end
         end
         OP_PUSH_A: begin
            meta_we = 1'b1;
            meta_wa = pp_ff[PAGE_W-1:0];
            meta_wd = '{head: 1'b1, in_use: 1'b0, ord: po_ff};
            nxt_we  = 1'b1;
            nxt_wa  = pp_ff[PAGE_W-1:0];
            nxt_wd  = EMPTY;
            prv_we  = 1'b1;
            prv_wa  = pp_ff[PAGE_W-1:0];
            prv_wd  = push_t;
            tail_in = push_t;
            if (push_t[LINK_W-1]) first_in[push_l] = LINK_W'(pp_ff);
            last_in[push_l] = LINK_W'(pp_ff);
         end
         OP_PUSH_B: begin
            nxt_we = 1'b1;
            nxt_wa = tail_ff[PAGE_W-1:0];
            nxt_wd = LINK_W'(pp_ff);
         end
         OP_SRCH: begin
            link_ra = srch_first[PAGE_W-1:0];
            if (!srch_first[LINK_W-1]) begin
               cur_in = CNT_W'(srch_first);
            end else if (srch_ff != ORD_W'(TOP_ORDER)) begin
               srch_in = srch_ff + ORD_W'(1);
            end
         end
         OP_UNLINK_HEAD: begin
            first_in[srch_l] = nxt_rd;
            if (!nxt_rd[LINK_W-1]) begin
               prv_we = 1'b1;
               prv_wa = nxt_rd[PAGE_W-1:0];
               prv_wd = EMPTY;
            end else begin
               last_in[srch_l] = EMPTY;
            end
            ord_in = srch_ff;
         end
         OP_SPLIT: begin
            if (ord_ff > rord_ff) begin
               pp_in  = cur_ff + (CNT_W'(1) << (ord_ff - ORD_W'(1)));
               po_in  = ord_ff - ORD_W'(1);
               ord_in = ord_ff - ORD_W'(1);
            end
         end
         OP_ALLOC_FIN: begin
            meta_we  = 1'b1;
            meta_wa  = cur_ff[PAGE_W-1:0];
            meta_wd  = '{head: 1'b1, in_use: 1'b1, ord: rord_ff};
            zf_in[zone_ff] = sat_sub(zf_ff[zone_ff], CNT_W'(1) << rord_ff);
         end
         OP_FREE_INIT: begin
            if (meta_rd.head && meta_rd.in_use) begin
               zone_in = (CNT_W'(s_ff) >= hz_ff);
               ord_in  = (meta_rd.ord > ORD_W'(TOP_ORDER)) ? ORD_W'(TOP_ORDER) : meta_rd.ord;
               zf_in[CNT_W'(s_ff) >= hz_ff] =
                  sat_add(zf_ff[CNT_W'(s_ff) >= hz_ff], CNT_W'(1) <<
                     ((meta_rd.ord > ORD_W'(TOP_ORDER)) ? ORD_W'(TOP_ORDER) : meta_rd.ord));
            end
         end
         OP_BUD_RD: begin
            meta_ra = bud[PAGE_W-1:0];
            link_ra = bud[PAGE_W-1:0];
            bud_in  = bud;
         end
         OP_BUD_MERGE: begin
            if (meta_rd.head && !meta_rd.in_use && (meta_rd.ord == ord_ff)) begin
               if (!prv_rd[LINK_W-1]) begin
                  nxt_we = 1'b1;
                  nxt_wa = prv_rd[PAGE_W-1:0];
                  nxt_wd = nxt_rd;
               end else begin
                  first_in[ord_l] = nxt_rd;
               end
               if (!nxt_rd[LINK_W-1]) begin
                  prv_we = 1'b1;
                  prv_wa = nxt_rd[PAGE_W-1:0];
                  prv_wd = prv_rd;
               end else begin
                  last_in[ord_l] = prv_rd;
               end
               meta_we = 1'b1;
               meta_wa = (bud_ff > cur_ff) ? bud_ff[PAGE_W-1:0] : cur_ff[PAGE_W-1:0];
               cur_in  = (bud_ff < cur_ff) ? bud_ff : cur_ff;
               ord_in  = ord_ff + ORD_W'(1);
            end
         end
         OP_FREE_PUSH: begin
            pp_in = cur_ff;
            po_in = ord_ff;
         end
         OP_RESULT: begin
            if (!rsp_busy) begin
               rv_in       = 1'b1;
               rcode_in    = cmd.code;
               rpage_in    = cmd.alloc ? cur_ff[PAGE_W-1:0] : '0;
               rord_out_in = cmd.alloc ? rord_ff : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hz_ff    <= MANAGED_MAX;
         total_ff <= '0;
         zf_ff[0] <= '0;
         zf_ff[1] <= '0;
         for (int i = 0; i < NLISTS; i++) begin
            first_ff[i] <= EMPTY;
            last_ff[i]  <= EMPTY;
         end
         clr_ff <= '0;
         rv_ff  <= 1'b0;
      end else begin
         if (csr_we && (csr_index == REG_HIGH_ZONE)) hz_ff <= csr_wdata;
         if (csr_we && (csr_index == REG_TOTAL)) total_ff <= csr_wdata;
         zf_ff    <= zf_in;
         first_ff <= first_in;
         last_ff  <= last_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;  s_ff <= s_in;  c_ff <= c_in;  e_ff <= e_in;
      scan_ff <= scan_in;  cur_ff <= cur_in;  len_ff <= len_in;  zone_ff <= zone_in;
      ord_ff <= ord_in;  rord_ff <= rord_in;  srch_ff <= srch_in;
      pp_ff <= pp_in;  po_ff <= po_in;  tail_ff <= tail_in;  bud_ff <= bud_in;
      rcode_ff <= rcode_in;  rpage_ff <= rpage_in;  rord_out_ff <= rord_out_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = RSP_DW'({rord_out_ff, rpage_ff, rcode_ff});
endmodule
`default_nettype wire

/* rtl/buddy_page_allocator.sv */
// buddy_page_allocator: top level joining the sequencer and the datapath
//
//  channel  | direction | fields
//  req_     | in        | tuser[1:0] req_type; tdata page_index[11:0], page_count[24:12]
//  rsp_     | out       | tdata status[1:0], block_page[13:2], block_order[17:14]
//  csr_     | in        | we, index (0 high zone first page, 1 total pages), wdata[12:0]
//
// steps: each request passes through acceptance, decode and the result; allocate adds
//    the search over the orders, the unlink and a push per split; free adds the descriptor
//    check, a buddy read and merge per merge level and a push; add adds a check per page,
//    the zone steps, and the carve of each zone with a push per carved block. page memories
//    (one read, one write port each) pace every step.
// reset: synchronous; afterwards a clearing pass over every page descriptor runs before
//    the first request is taken.
// stalls: a finished result waits in the output register; the next request is taken
//    meanwhile, and its own result waits until that register frees.
`default_nettype none
module buddy_page_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // page_index, page_count
   input  wire logic [1:0]  req_tuser,   // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata,   // status, block_page, block_order
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [12:0] csr_wdata
);
   import bpa_pkg::*;

   cmd_type       cmd;
   dp_status_type stat;

   bpa_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .stat(stat), .cmd(cmd));

   bpa_dpath u_dpath (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_tdata(req_tdata), .req_tuser(req_tuser),
      .cmd(cmd), .stat(stat), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata));
endmodule
`default_nettype wire

/* rtl/bpa_check.sv */
// bpa_check: port-level checks on the allocator's result channel
`default_nettype none
module bpa_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);
   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // only defined status codes
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("undefined status code");

   // failed requests carry no block
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != 2'd0 |-> rsp_tdata[17:2] == 16'd0)
      else $error("failed request returned a block");

   // block order within range
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[17:14] <= 4'd10)
      else $error("block order out of range");
endmodule

bind buddy_page_allocator bpa_check u_bpa_check (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata));
`default_nettype wire
